// ----- rtl/i2cmbs_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cmbs_pkg
// shared types and constants of the i2c master bit sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmbs_pkg;

  localparam int unsigned WaitW      = 15;
  localparam int unsigned CountW     = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned BitIdxW    = 4;
  localparam int unsigned CmdW       = 3;
  localparam int unsigned RegIdxW    = 1;
  localparam int unsigned QueueDepth = 2;

  localparam logic [WaitW-1:0] WaitUnitsRst   = WaitW'(300);
  localparam logic             SdaInvertedRst = 1'b1;

  typedef enum logic [CmdW-1:0] {
    CMD_START     = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_READ_ACK  = 3'd2,
    CMD_READ_NACK = 3'd3,
    CMD_STOP      = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_NOP  = 2'd2
  } kind_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_WAIT_UNITS  = 1'b0,
    REG_SDA_INVERTED = 1'b1
  } reg_idx_e;

  typedef struct packed {
    kind_e            kind;
    cmd_e             cmd;
    logic [ByteW-1:0] tx_byte;
    logic             sda_sample;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

`default_nettype wire

// ----- rtl/i2cmbs_if.sv -----
// ----------------------------------------------------------------------------
// i2cmbs channel interfaces
// input item, result item and register write channels
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cmbs_item_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [2:0] command;
  logic [7:0] tx_byte;
  logic       sda_sample;

  modport source (output valid, action, command, tx_byte, sda_sample, input ready);
  modport sink   (input valid, action, command, tx_byte, sda_sample, output ready);
endinterface

interface i2cmbs_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_pin;
  logic       sda_released;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_missing;

  modport source (output valid, scl_level, sda_pin, sda_released, busy_res, done_res,
                  rx_byte, ack_missing, input ready);
  modport sink   (input valid, scl_level, sda_pin, sda_released, busy_res, done_res,
                  rx_byte, ack_missing, output ready);
endinterface

interface i2cmbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [14:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/i2cmbs_front.sv -----
// ----------------------------------------------------------------------------
// i2cmbs_front
// accepts input items, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmbs_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  i2cmbs_item_if.sink            item_i,
  input  wire                    pop_i,
  output i2cmbs_pkg::queue_head_t head_o
);

  localparam int unsigned PtrW = $clog2(i2cmbs_pkg::QueueDepth);

  i2cmbs_pkg::item_t mem_q [i2cmbs_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     count_q;
  i2cmbs_pkg::item_t cls;
  logic              push, pop;

  always_comb begin
    cls.tx_byte    = item_i.tx_byte;
    cls.sda_sample = item_i.sda_sample;
    cls.cmd        = i2cmbs_pkg::cmd_e'(item_i.command);
    if (!item_i.action) begin
      cls.kind = i2cmbs_pkg::KIND_TICK;
    end else if (item_i.command <= i2cmbs_pkg::CMD_STOP) begin
      cls.kind = i2cmbs_pkg::KIND_CMD;
    end else begin
      cls.kind = i2cmbs_pkg::KIND_NOP;
    end
  end

  assign item_i.ready = (count_q != (PtrW+1)'(i2cmbs_pkg::QueueDepth));
  assign push         = item_i.valid && item_i.ready;
  assign pop          = pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + (PtrW+1)'(1);
        2'b01:   count_q <= count_q - (PtrW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/i2cmbs_back.sv -----
// ----------------------------------------------------------------------------
// i2cmbs_back
// bus sequencer: runs one queued item per cycle while the result side is not stalled, and registers its result
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmbs_back (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire i2cmbs_pkg::queue_head_t head_i,
  output logic                    pop_o,
  i2cmbs_cfg_if.sink              cfg_i,
  i2cmbs_res_if.source            res_o
);

  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    PH_S_A   = 5'd1,
    PH_S_B   = 5'd2,
    PH_S_C   = 5'd3,
    PH_S_D   = 5'd4,
    PH_W_HI  = 5'd5,
    PH_W_LO  = 5'd6,
    PH_W_ACK = 5'd7,
    PH_W_CHK = 5'd8,
    PH_W_END = 5'd9,
    PH_R_HI  = 5'd10,
    PH_R_SMP = 5'd11,
    PH_R_END = 5'd12,
    PH_K_HI  = 5'd13,
    PH_K_LO  = 5'd14,
    PH_K_FIN = 5'd15,
    PH_P_HI  = 5'd16,
    PH_P_END = 5'd17
  } phase_e;

  localparam int unsigned CntW = i2cmbs_pkg::CountW;
  localparam int unsigned BW   = i2cmbs_pkg::ByteW;
  localparam int unsigned IdxW = i2cmbs_pkg::BitIdxW;

  logic [i2cmbs_pkg::WaitW-1:0] wait_units_q;
  logic                         sda_inv_q;

  phase_e           ph_q, ph_d;
  logic [IdxW-1:0]  bit_q, bit_d;
  logic [BW-1:0]    sh_q, sh_d;
  logic [CntW-1:0]  cnt_q, cnt_d, cnt_dec;
  logic             scl_q, scl_d;
  logic             sda_q, sda_d;
  logic             sin_q, sin_d;
  i2cmbs_pkg::cmd_e acmd_q, acmd_d;
  logic             nack_q, nack_d;
  logic [BW-1:0]    rx_q, rx_d;
  logic             done;
  logic             out_valid_q;

  logic [i2cmbs_pkg::WaitW-1:0] half;
  logic [CntW-1:0]              full16, half16;
  logic [IdxW-1:0]              bit_inc;
  logic [BW-1:0]                sh_wr, sh_rd;
  i2cmbs_pkg::item_t            it;

  assign cfg_i.ready = 1'b1;
  assign pop_o       = head_i.valid && (!out_valid_q || res_o.ready);
  assign res_o.valid = out_valid_q;
  assign it          = head_i.item;

  assign half    = (wait_units_q == '0) ? i2cmbs_pkg::WaitW'(1) : wait_units_q;
  assign full16  = {half, 1'b0};
  assign half16  = {1'b0, half};
  assign cnt_dec = (cnt_q != '0) ? cnt_q - CntW'(1) : cnt_q;
  assign bit_inc = bit_q + IdxW'(1);
  assign sh_wr   = {sh_q[BW-2:0], 1'b0};
  assign sh_rd   = {sh_q[BW-2:0], it.sda_sample};

  always_comb begin
    ph_d   = ph_q;
    bit_d  = bit_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    scl_d  = scl_q;
    sda_d  = sda_q;
    sin_d  = sin_q;
    acmd_d = acmd_q;
    nack_d = nack_q;
    rx_d   = rx_q;
    done   = 1'b0;
    case (it.kind)
      i2cmbs_pkg::KIND_CMD: begin
        if (ph_q == PH_IDLE) begin
          acmd_d = it.cmd;
          cnt_d  = full16;
          case (it.cmd)
            i2cmbs_pkg::CMD_START: begin
              sin_d = 1'b0; sda_d = 1'b1; scl_d = 1'b1;
              ph_d  = PH_S_A;
            end
            i2cmbs_pkg::CMD_WRITE: begin
              scl_d = 1'b0;
              sh_d  = it.tx_byte;
              bit_d = '0;
              sda_d = it.tx_byte[BW-1];
              ph_d  = PH_W_HI;
            end
            i2cmbs_pkg::CMD_READ_ACK, i2cmbs_pkg::CMD_READ_NACK: begin
              sin_d = 1'b1; sda_d = 1'b1;
              sh_d  = '0; bit_d = '0;
              scl_d = 1'b0;
              ph_d  = PH_R_HI;
            end
            default: begin
              sin_d = 1'b0; sda_d = 1'b0; scl_d = 1'b0;
              ph_d  = PH_P_HI;
            end
          endcase
        end
      end
      i2cmbs_pkg::KIND_TICK: begin
        if (ph_q != PH_IDLE) begin
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            case (ph_q)
              PH_S_A: begin sda_d = 1'b0; cnt_d = full16; ph_d = PH_S_B; end
              PH_S_B: begin cnt_d = full16; ph_d = PH_S_C; end
              PH_S_C: begin scl_d = 1'b0; cnt_d = full16; ph_d = PH_S_D; end
              PH_W_HI: begin scl_d = 1'b1; cnt_d = half16; ph_d = PH_W_LO; end
              PH_W_LO: begin
                scl_d = 1'b0;
                sh_d  = sh_wr;
                bit_d = bit_inc;
                cnt_d = full16;
                if (bit_inc < IdxW'(BW)) begin
                  sda_d = sh_wr[BW-1];
                  ph_d  = PH_W_HI;
                end else begin
                  sda_d = 1'b1;
                  ph_d  = PH_W_ACK;
                end
              end
              PH_W_ACK: begin
                sin_d = 1'b1; scl_d = 1'b1; cnt_d = full16; ph_d = PH_W_CHK;
              end
              PH_W_CHK: begin
                scl_d = 1'b0;
                if (it.sda_sample) begin
                  nack_d = 1'b1;
                  done   = 1'b1;
                end else begin
                  nack_d = 1'b0;
                  cnt_d  = full16;
                  ph_d   = PH_W_END;
                end
              end
              PH_W_END: begin sda_d = 1'b1; sin_d = 1'b0; done = 1'b1; end
              PH_R_HI: begin scl_d = 1'b1; cnt_d = half16; ph_d = PH_R_SMP; end
              PH_R_SMP: begin
                sh_d  = sh_rd;
                bit_d = bit_inc;
                cnt_d = full16;
                if (bit_inc < IdxW'(BW)) begin
                  scl_d = 1'b0;
                  ph_d  = PH_R_HI;
                end else begin
                  ph_d  = PH_R_END;
                end
              end
              PH_R_END: begin
                scl_d = 1'b0;
                sin_d = 1'b0;
                rx_d  = sh_q;
                sda_d = (acmd_q != i2cmbs_pkg::CMD_READ_ACK);
                cnt_d = full16;
                ph_d  = PH_K_HI;
              end
              PH_K_HI: begin scl_d = 1'b1; cnt_d = full16; ph_d = PH_K_LO; end
              PH_K_LO: begin
                scl_d = 1'b0;
                if (acmd_q == i2cmbs_pkg::CMD_READ_ACK) begin
                  cnt_d = full16;
                  ph_d  = PH_K_FIN;
                end else begin
                  done = 1'b1;
                end
              end
              PH_P_HI: begin scl_d = 1'b1; cnt_d = full16; ph_d = PH_P_END; end
              PH_P_END: begin sda_d = 1'b1; done = 1'b1; end
              default: done = 1'b1;
            endcase
            if (done) begin
              ph_d  = PH_IDLE;
              cnt_d = '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_units_q <= i2cmbs_pkg::WaitUnitsRst;
      sda_inv_q    <= i2cmbs_pkg::SdaInvertedRst;
      ph_q         <= PH_IDLE;
      bit_q        <= '0;
      sh_q         <= '0;
      cnt_q        <= '0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      sin_q        <= 1'b0;
      acmd_q       <= i2cmbs_pkg::CMD_START;
      nack_q       <= 1'b0;
      rx_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          i2cmbs_pkg::REG_WAIT_UNITS:   wait_units_q <= cfg_i.data;
          i2cmbs_pkg::REG_SDA_INVERTED: sda_inv_q    <= cfg_i.data[0];
          default: ;
        endcase
      end
      if (pop_o) begin
        ph_q   <= ph_d;
        bit_q  <= bit_d;
        sh_q   <= sh_d;
        cnt_q  <= cnt_d;
        scl_q  <= scl_d;
        sda_q  <= sda_d;
        sin_q  <= sin_d;
        acmd_q <= acmd_d;
        nack_q <= nack_d;
        rx_q   <= rx_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register, loaded with the state after the item
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_o.scl_level    <= scl_d;
      res_o.sda_pin      <= sda_d ^ sda_inv_q;
      res_o.sda_released <= sin_d;
      res_o.busy_res     <= (ph_d != PH_IDLE);
      res_o.done_res     <= done;
      res_o.rx_byte      <= rx_d;
      res_o.ack_missing  <= nack_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/i2c_master_bit_sequencer.sv -----
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// i2c master taking byte commands and time ticks, one result per item
// an accepted item is written into the queue, then stepped into the result register, which sets result valid
// throughput: one item per cycle while the result side accepts results, as the sequencer handles each item in one step
// the two-entry queue lets input and result sides stall independently
// reset: asynchronous active low; bus idle with scl and sda high, registers at defaults
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer (
  input  wire          clk_i,
  input  wire          rst_ni,
  i2cmbs_item_if.sink  item_i,
  i2cmbs_cfg_if.sink   cfg_i,
  i2cmbs_res_if.source res_o
);

  i2cmbs_pkg::queue_head_t head;
  logic                    pop;

  i2cmbs_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_i),
    .pop_i  (pop),
    .head_o (head)
  );

  i2cmbs_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .cfg_i  (cfg_i),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire
